@@ rtl/lsp_pkg.sv @@
package lsp_pkg;

    // Store geometry
    localparam int LOOP_LENGTH = 65536;
    localparam int CHANNELS    = 2;
    localparam int ADDR_W      = $clog2(LOOP_LENGTH);

    // Field widths
    localparam int FUNC_W     = 2;
    localparam int CHAN_W     = 1;
    localparam int PTR_W      = 16;
    localparam int SAMPLE_W   = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Reset values of the loop registers
    localparam logic [PTR_W-1:0] OPEN_RESET  = 16'd0;
    localparam logic [PTR_W-1:0] CLOSE_RESET = 16'd65535;

    // Front-to-back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PLAY  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_SET   = 2'd2
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OPEN    = 2'd0,
        CFG_CLOSE   = 2'd1,
        CFG_REVERSE = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } op_kind_t;

    // One memory operation handed from front to back
    typedef struct packed {
        op_kind_t                   kind;
        logic [CHAN_W-1:0]          channel;
        logic [ADDR_W-1:0]          addr;
        logic                       in_range;
        logic signed [SAMPLE_W-1:0] sample;
    } mem_op_t;

    typedef struct packed {
        logic    push;
        mem_op_t op;
    } queue_wr_t;

    typedef struct packed {
        logic    valid;
        mem_op_t op;
    } queue_rd_t;

endpackage

@@ rtl/loop_sample_player.sv @@
// Channel  Direction  Handshake              Payload
// item     in         in_valid / in_stall    func, channel, sample_address, sample_in
// result   out        out_valid / out_stall  channel_out, sample_out
// config   in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle sustained while in_stall is low; a play result passes through
// a queue slot, the registered read of the store bank and the result buffer.
// After reset the store banks are swept to zero at all 65536 addresses, one address
// of every bank per cycle, with in_stall high; config writes are taken throughout.
// A stalled result queues up behind a two-entry buffer, then the front queue
// fills and in_stall rises; set items never reach the store.
module loop_sample_player (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [lsp_pkg::FUNC_W-1:0]          func,
    input  logic [lsp_pkg::CHAN_W-1:0]          channel,
    input  logic [lsp_pkg::PTR_W-1:0]           sample_address,
    input  logic signed [lsp_pkg::SAMPLE_W-1:0] sample_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [lsp_pkg::CHAN_W-1:0]          channel_out,
    output logic signed [lsp_pkg::SAMPLE_W-1:0] sample_out,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lsp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lsp_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import lsp_pkg::*;

    queue_wr_t queue_wr;
    queue_rd_t queue_head;
    logic      queue_full;
    logic      queue_pop;
    logic      clearing;

    lsp_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .channel        (channel),
        .sample_address (sample_address),
        .sample_in      (sample_in),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .queue_full     (queue_full),
        .clearing       (clearing),
        .queue_wr       (queue_wr)
    );

    lsp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (queue_wr),
        .pop   (queue_pop),
        .full  (queue_full),
        .head  (queue_head)
    );

    lsp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (queue_head),
        .pop         (queue_pop),
        .clearing    (clearing),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .channel_out (channel_out),
        .sample_out  (sample_out)
    );

endmodule

@@ rtl/lsp_ram.sv @@
module lsp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/lsp_front.sv @@
module lsp_front (
    input  logic                              clk,
    input  logic                              rst_n,
    // item channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [lsp_pkg::FUNC_W-1:0]        func,
    input  logic [lsp_pkg::CHAN_W-1:0]        channel,
    input  logic [lsp_pkg::PTR_W-1:0]         sample_address,
    input  logic signed [lsp_pkg::SAMPLE_W-1:0] sample_in,
    // configuration channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lsp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lsp_pkg::CFG_DATA_W-1:0]    cfg_data,
    // queue and back status
    input  logic                              queue_full,
    input  logic                              clearing,
    output lsp_pkg::queue_wr_t                queue_wr
);

    import lsp_pkg::*;

    logic [PTR_W-1:0] open_brace_reg;
    logic [PTR_W-1:0] close_brace_reg;
    logic             reverse_play_reg;
    logic [PTR_W-1:0] read_pointer_reg  [CHANNELS];
    logic [PTR_W-1:0] read_pointer_next [CHANNELS];

    logic                accept;
    logic                chan_ok;
    logic [PTR_W-1:0]    cur_ptr;
    logic [PTR_W-1:0]    adv_ptr;
    logic [PTR_W:0]      fwd_n;
    logic signed [PTR_W+1:0] rev_n;

    assign in_stall  = clearing | queue_full;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid & ~in_stall;
    assign chan_ok   = 32'(channel) < CHANNELS;
    assign cur_ptr   = read_pointer_reg[channel];

    // Loop pointer advance: forward wraps at close, reverse wraps at open
    assign fwd_n = {1'b0, cur_ptr} + (PTR_W+1)'(1);
    assign rev_n = $signed({2'b00, cur_ptr}) - (PTR_W+2)'(1);

    always_comb
    begin
        if (reverse_play_reg)
        begin
            if (rev_n <= $signed({2'b00, open_brace_reg}))
            begin
                adv_ptr = close_brace_reg;
            end
            else
            begin
                adv_ptr = rev_n[PTR_W-1:0];
            end
        end
        else
        begin
            if (fwd_n >= {1'b0, close_brace_reg})
            begin
                adv_ptr = open_brace_reg;
            end
            else
            begin
                adv_ptr = fwd_n[PTR_W-1:0];
            end
        end
    end

    // Classify the item: pointer update here, memory work to the queue
    always_comb
    begin
        read_pointer_next = read_pointer_reg;
        queue_wr.push        = 1'b0;
        queue_wr.op.kind     = OP_READ;
        queue_wr.op.channel  = channel;
        queue_wr.op.addr     = ADDR_W'(cur_ptr);
        queue_wr.op.in_range = 32'(cur_ptr) < LOOP_LENGTH;
        queue_wr.op.sample   = sample_in;
        if (accept && chan_ok)
        begin
            case (func_t'(func))
                FUNC_PLAY:
                begin
                    read_pointer_next[channel] = adv_ptr;
                    queue_wr.push = 1'b1;
                end
                FUNC_WRITE:
                begin
                    queue_wr.op.kind     = OP_WRITE;
                    queue_wr.op.addr     = ADDR_W'(sample_address);
                    queue_wr.op.in_range = 1'b1;
                    queue_wr.push        = 32'(sample_address) < LOOP_LENGTH;
                end
                FUNC_SET:
                begin
                    read_pointer_next[channel] = sample_address;
                end
                default:
                begin
                    // unused code: dropped
                end
            endcase
        end
    end

    // Pointer and loop registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                read_pointer_reg[i] <= '0;
            end
            open_brace_reg   <= OPEN_RESET;
            close_brace_reg  <= CLOSE_RESET;
            reverse_play_reg <= 1'b0;
        end
        else
        begin
            read_pointer_reg <= read_pointer_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_OPEN:    open_brace_reg   <= cfg_data;
                    CFG_CLOSE:   close_brace_reg  <= cfg_data;
                    CFG_REVERSE: reverse_play_reg <= cfg_data[0];
                    default:
                    begin
                        // unknown index: ignored
                    end
                endcase
            end
        end
    end

endmodule

@@ rtl/lsp_queue.sv @@
module lsp_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  lsp_pkg::queue_wr_t wr,
    input  logic               pop,
    output logic               full,
    output lsp_pkg::queue_rd_t head
);

    import lsp_pkg::*;

    mem_op_t           entry_reg [QUEUE_DEPTH];
    logic [QIDX_W-1:0] wr_ptr_reg;
    logic [QIDX_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_pop;

    assign full       = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign head.valid = count_reg != '0;
    assign head.op    = entry_reg[rd_ptr_reg];
    assign do_pop     = pop & head.valid;

    always_comb
    begin
        count_next = count_reg;
        if (wr.push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (!wr.push && do_pop)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    // Payload storage
    always_ff @(posedge clk)
    begin
        if (wr.push)
        begin
            entry_reg[wr_ptr_reg] <= wr.op;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr.push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QIDX_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QIDX_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/lsp_back.sv @@
module lsp_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lsp_pkg::queue_rd_t                  head,
    output logic                                pop,
    output logic                                clearing,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [lsp_pkg::CHAN_W-1:0]          channel_out,
    output logic signed [lsp_pkg::SAMPLE_W-1:0] sample_out
);

    import lsp_pkg::*;

    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    logic              s1_valid_reg;
    logic [CHAN_W-1:0] s1_channel_reg;
    logic              s1_in_range_reg;

    logic [CHAN_W-1:0]          of_ch_reg  [2];
    logic signed [SAMPLE_W-1:0] of_smp_reg [2];
    logic                       of_wr_reg;
    logic                       of_rd_reg;
    logic [1:0]                 of_cnt_reg;

    logic [SAMPLE_W-1:0] rdata [CHANNELS];
    logic [SAMPLE_W-1:0] read_data;
    logic                deq;
    logic [2:0]          pending;
    logic                issue_ok;
    logic                issue_read;
    logic                issue_write;

    assign clearing = clearing_reg;

    // Reads are issued only when the result buffer has room once they land
    assign deq      = out_valid & ~out_stall;
    assign pending  = 3'(of_cnt_reg) + 3'(s1_valid_reg) - 3'(deq);
    assign issue_ok = pending < 3'd2;

    assign pop = head.valid & ~clearing_reg & ((head.op.kind == OP_WRITE) | issue_ok);
    assign issue_read  = pop & (head.op.kind == OP_READ);
    assign issue_write = pop & (head.op.kind == OP_WRITE);

    // One store bank per channel, cleared in parallel after reset
    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_bank
        logic              bank_we;
        logic              bank_re;
        logic [ADDR_W-1:0] bank_addr;
        logic [SAMPLE_W-1:0] bank_wdata;

        assign bank_we    = clearing_reg | (issue_write & (head.op.channel == CHAN_W'(i)));
        assign bank_re    = issue_read & (head.op.channel == CHAN_W'(i));
        assign bank_addr  = clearing_reg ? clr_addr_reg : head.op.addr;
        assign bank_wdata = clearing_reg ? '0 : head.op.sample;

        lsp_ram #(
            .WIDTH (SAMPLE_W),
            .DEPTH (LOOP_LENGTH)
        ) u_ram (
            .clk   (clk),
            .we    (bank_we),
            .re    (bank_re),
            .addr  (bank_addr),
            .wdata (bank_wdata),
            .rdata (rdata[i])
        );
    end

    // Out-of-range pointer plays back silence
    assign read_data = s1_in_range_reg ? rdata[s1_channel_reg] : '0;

    // Result buffer head
    assign out_valid   = of_cnt_reg != 2'd0;
    assign channel_out = of_ch_reg[of_rd_reg];
    assign sample_out  = of_smp_reg[of_rd_reg];

    // Read stage and result buffer payload
    always_ff @(posedge clk)
    begin
        s1_channel_reg  <= head.op.channel;
        s1_in_range_reg <= head.op.in_range;
        if (s1_valid_reg)
        begin
            of_ch_reg[of_wr_reg]  <= s1_channel_reg;
            of_smp_reg[of_wr_reg] <= $signed(read_data);
        end
    end

    // Control: clear sweep, read in flight, buffer pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            s1_valid_reg <= 1'b0;
            of_wr_reg    <= 1'b0;
            of_rd_reg    <= 1'b0;
            of_cnt_reg   <= 2'd0;
        end
        else
        begin
            if (clearing_reg)
            begin
                if (clr_addr_reg == ADDR_W'(LOOP_LENGTH - 1))
                begin
                    clearing_reg <= 1'b0;
                end
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            s1_valid_reg <= issue_read;
            if (s1_valid_reg)
            begin
                of_wr_reg <= ~of_wr_reg;
            end
            if (deq)
            begin
                of_rd_reg <= ~of_rd_reg;
            end
            of_cnt_reg <= of_cnt_reg + 2'(s1_valid_reg) - 2'(deq);
        end
    end

endmodule
